// ===== hw/rtl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int NUM_DIGITS_DEF = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int VALUE_W        = 14;

  localparam logic [7:0]  SEG_BLANK  = 8'hFF;
  localparam logic [7:0]  SEG_ALL_ON = 8'h00;
  localparam logic [12:0] RECIP_TEN  = 13'd6554;

  typedef enum logic [2:0] {
    KIND_DIGIT   = 3'd0,
    KIND_LETTER  = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_REFRESH = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OP_STORE,
    OP_NUMBER,
    OP_FILL,
    OP_CLEAR,
    OP_REFRESH
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_LOAD,
    ST_FRAME
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [1:0]         pos;
    logic [7:0]         pattern;
    logic [VALUE_W-1:0] value;
    logic               keep;
  } cmd_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] seg;
    unique case (d)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] letter_seg(input logic [4:0] l);
    logic [7:0] seg;
    unique case (l)
      5'd0:    seg = 8'h88;
      5'd1:    seg = 8'h83;
      5'd2:    seg = 8'hC6;
      5'd3:    seg = 8'hA1;
      5'd4:    seg = 8'h86;
      5'd5:    seg = 8'h8E;
      5'd6:    seg = 8'hC2;
      5'd7:    seg = 8'h89;
      5'd8:    seg = 8'hF9;
      5'd9:    seg = 8'hF1;
      5'd10:   seg = 8'h8A;
      5'd11:   seg = 8'hC7;
      5'd12:   seg = 8'hC8;
      5'd13:   seg = 8'hAB;
      5'd14:   seg = 8'hC0;
      5'd15:   seg = 8'h8C;
      5'd16:   seg = 8'h98;
      5'd17:   seg = 8'hAF;
      5'd18:   seg = 8'h92;
      5'd19:   seg = 8'h87;
      5'd20:   seg = 8'hC1;
      5'd21:   seg = 8'hC1;
      5'd22:   seg = 8'h85;
      5'd23:   seg = 8'h89;
      5'd24:   seg = 8'h91;
      5'd25:   seg = 8'hA4;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] select_byte(input logic [1:0] i);
    logic [7:0] sel;
    unique case (i)
      2'd0:    sel = 8'hF1;
      2'd1:    sel = 8'hF2;
      2'd2:    sel = 8'hF4;
      default: sel = 8'hF8;
    endcase
    return sel;
  endfunction

endpackage

// ===== hw/rtl/ssd_if.sv =====
interface ssd_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [2:0]         position;
  logic [7:0]         char_code;
  logic signed [15:0] number;
  logic               leading_zeros;

  modport source (output valid, kind, position, char_code, number, leading_zeros,
                  input ready);
  modport sink   (input valid, kind, position, char_code, number, leading_zeros,
                  output ready);
endinterface

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_pattern;
  logic [7:0] digit_select;
  logic       last;

  modport source (output valid, segment_pattern, digit_select, last, input ready);
  modport sink   (input valid, segment_pattern, digit_select, last, output ready);
endinterface

// ===== hw/rtl/ssd_front.sv =====
module ssd_front
  import ssd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  ssd_in_if.sink in_chan,
  input  logic   q_full,
  output logic   q_push,
  output cmd_t   q_data
);

  localparam logic [14:0] MaxValue = 15'(10 ** NUM_DIGITS - 1);

  logic       accept;
  logic       pos_ok;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] letter_off;
  logic       keep_item;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign q_push        = accept && keep_item;

  assign pos_ok     = in_chan.position < 3'(NUM_DIGITS);
  assign is_upper   = (in_chan.char_code >= 8'h41) && (in_chan.char_code <= 8'h5A);
  assign is_lower   = (in_chan.char_code >= 8'h61) && (in_chan.char_code <= 8'h7A);
  assign letter_off = is_upper ? (in_chan.char_code - 8'h41) : (in_chan.char_code - 8'h61);

  always_comb begin
    keep_item      = 1'b0;
    q_data.op      = OP_STORE;
    q_data.pos     = in_chan.position[1:0];
    q_data.pattern = digit_seg(in_chan.char_code[3:0]);
    q_data.value   = in_chan.number[VALUE_W-1:0];
    q_data.keep    = in_chan.leading_zeros;
    unique case (in_chan.kind)
      KIND_DIGIT: begin
        keep_item = pos_ok && (in_chan.char_code <= 8'd9);
      end
      KIND_LETTER: begin
        keep_item      = pos_ok && (is_upper || is_lower);
        q_data.pattern = letter_seg(letter_off[4:0]);
      end
      KIND_NUMBER: begin
        keep_item = 1'b1;
        if (!in_chan.number[15] && (in_chan.number[14:0] <= MaxValue)) begin
          q_data.op = OP_NUMBER;
        end else begin
          q_data.op = OP_FILL;
        end
      end
      KIND_CLEAR: begin
        keep_item = 1'b1;
        q_data.op = OP_CLEAR;
      end
      KIND_REFRESH: begin
        keep_item = 1'b1;
        q_data.op = OP_REFRESH;
      end
      default: begin
        keep_item = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ssd_queue.sv =====
module ssd_queue
  import ssd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = count_r == CntW'(DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/ssd_back.sv =====
module ssd_back
  import ssd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  cmd_t     q_data,
  output logic     q_pop,
  ssd_out_if.source out_chan
);

  localparam int IdxW  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int ProdW = VALUE_W + 13;

  state_t             state_r, state_nxt;
  logic [7:0]         store_r [NUM_DIGITS];
  logic [7:0]         store_nxt [NUM_DIGITS];
  logic [3:0]         dig_r [NUM_DIGITS];
  logic [3:0]         dig_nxt [NUM_DIGITS];
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               keep_r, keep_nxt;
  logic               clear_r, clear_nxt;
  logic [IdxW-1:0]    idx_r, idx_nxt;
  logic [IdxW-1:0]    scan_r, scan_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_pat_r, out_pat_nxt;
  logic [7:0]         out_sel_r, out_sel_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               idx_last;
  logic [ProdW-1:0]   prod;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] rem;
  logic               sig;

  assign out_free = !out_valid_r || out_chan.ready;
  assign idx_last = idx_r == IdxW'(NUM_DIGITS - 1);

  assign prod = ProdW'(val_r) * ProdW'(RECIP_TEN);
  assign quo  = VALUE_W'(prod[ProdW-1:16]);
  assign rem  = val_r - ((quo << 3) + (quo << 1));

  assign out_chan.valid           = out_valid_r;
  assign out_chan.segment_pattern = out_pat_r;
  assign out_chan.digit_select    = out_sel_r;
  assign out_chan.last            = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_data.op)
            OP_NUMBER:             state_nxt = ST_SPLIT;
            OP_CLEAR, OP_REFRESH:  state_nxt = ST_FRAME;
            default:               state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SPLIT: begin
        if (idx_r == '0) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_IDLE;
      end
      ST_FRAME: begin
        if (out_free && (!clear_r || idx_last)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    store_nxt     = store_r;
    dig_nxt       = dig_r;
    val_nxt       = val_r;
    keep_nxt      = keep_r;
    clear_nxt     = clear_r;
    idx_nxt       = idx_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pat_nxt   = out_pat_r;
    out_sel_nxt   = out_sel_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    sig           = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        q_pop = !q_empty;
        if (!q_empty) begin
          unique case (q_data.op)
            OP_STORE: begin
              store_nxt[q_data.pos[IdxW-1:0]] = q_data.pattern;
            end
            OP_NUMBER: begin
              val_nxt  = q_data.value;
              keep_nxt = q_data.keep;
              idx_nxt  = IdxW'(NUM_DIGITS - 1);
            end
            OP_FILL: begin
              for (int i = 0; i < NUM_DIGITS; i++) begin
                store_nxt[i] = SEG_ALL_ON;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < NUM_DIGITS; i++) begin
                store_nxt[i] = SEG_BLANK;
              end
              clear_nxt = 1'b1;
              idx_nxt   = '0;
            end
            default: begin
              clear_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SPLIT: begin
        dig_nxt[idx_r] = rem[3:0];
        val_nxt        = quo;
        idx_nxt        = idx_r - 1'b1;
      end
      ST_LOAD: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          sig = sig || (dig_r[i] != 4'd0);
          if (sig || keep_r || (i == NUM_DIGITS - 1)) begin
            store_nxt[i] = digit_seg(dig_r[i]);
          end else begin
            store_nxt[i] = SEG_BLANK;
          end
        end
      end
      ST_FRAME: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (clear_r) begin
            out_pat_nxt  = SEG_BLANK;
            out_sel_nxt  = select_byte(2'(idx_r));
            out_last_nxt = idx_last;
            idx_nxt      = idx_r + 1'b1;
          end else begin
            out_pat_nxt  = store_r[scan_r];
            out_sel_nxt  = select_byte(2'(scan_r));
            out_last_nxt = 1'b1;
            scan_nxt     = (scan_r == IdxW'(NUM_DIGITS - 1)) ? '0 : scan_r + 1'b1;
          end
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store_r[i] <= SEG_BLANK;
      end
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      store_r     <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    val_r      <= val_nxt;
    keep_r     <= keep_nxt;
    clear_r    <= clear_nxt;
    idx_r      <= idx_nxt;
    out_pat_r  <= out_pat_nxt;
    out_sel_r  <= out_sel_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== hw/rtl/seven_segment_scan_driver_core.sv =====
// Four-position multiplexed seven-segment display driver.
// The input channel carries commands: digit write, letter write, number
// write, clear and refresh tick. Writes update the stored active-low
// segment patterns and produce no output. A refresh tick produces one
// frame (segment pattern and digit select) for the current scan position
// and advances the scan position. A clear blanks all positions and
// produces one blank frame per position, the final one marked by last.
// Accepted commands enter a two-entry queue; the execution side takes one
// command at a time. An in-range number write is converted by the digit
// split, which extracts one decimal digit per cycle with a reciprocal
// multiply, before the new patterns are loaded into the stored positions.
// Commands that are ignored are dropped on transfer.
// After reset all positions are blank, the scan position is zero and the
// output is empty. When the receiver stalls, the current frame holds in
// the output register, the queue fills and then input ready drops.
module seven_segment_scan_driver_core
  import ssd_pkg::*;
#(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_in_if.sink     in_chan,
  ssd_out_if.source  out_chan
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_push_data;
  cmd_t q_pop_data;

  ssd_front #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_front (
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_push_data)
  );

  ssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  ssd_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== hw/rtl/ssd_checker.sv =====
module ssd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pattern,
  input logic [7:0] out_select,
  input logic       out_last
);

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Output valid dropped while stalled.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_pattern) && $stable(out_select) && $stable(out_last))
    else $error("Output payload changed while stalled.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_select == 8'hF1 || out_select == 8'hF2 ||
                   out_select == 8'hF4 || out_select == 8'hF8))
    else $error("Digit select is not a single position.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_pattern == 8'hFF)
    else $error("A frame that is not last must be a blank clear frame.");

endmodule

bind seven_segment_scan_driver_core ssd_checker u_ssd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_pattern (out_chan.segment_pattern),
  .out_select  (out_chan.digit_select),
  .out_last    (out_chan.last)
);

// ===== sim/tb_seven_segment_scan_driver_core.sv =====
`timescale 1ns / 1ps

module tb_seven_segment_scan_driver_core;
  import ssd_pkg::*;

  localparam int         POSITIONS      = 4;
  localparam int         MAX_SHOWN      = 9999;
  localparam int         TARGET_ITEMS   = 64;
  localparam int         DRAIN_CYCLES   = 20;
  localparam logic [7:0] ASCII_UPPER_A  = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z  = 8'h5A;
  localparam logic [7:0] ASCII_LOWER_A  = 8'h61;
  localparam logic [7:0] ASCII_LOWER_Z  = 8'h7A;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef struct {
    logic [2:0]         kind;
    logic [2:0]         position;
    logic [7:0]         char_code;
    logic signed [15:0] number;
    logic               leading_zeros;
  } command_t;

  typedef struct {
    logic [7:0] pattern;
    logic [7:0] sel_byte;
    logic       last;
  } frame_t;

  class frame_scoreboard;
    logic [7:0] glyphs [POSITIONS];
    logic [1:0] scan_pos;
    frame_t     pending [$];
    int         errors;
    int         commands;
    int         frames_checked;

    function new();
      for (int i = 0; i < POSITIONS; i++) glyphs[i] = SEG_BLANK;
      scan_pos       = '0;
      errors         = 0;
      commands       = 0;
      frames_checked = 0;
    endfunction

    function logic [7:0] digit_glyph(int d);
      case (d)
        0:       return 8'hC0;
        1:       return 8'hF9;
        2:       return 8'hA4;
        3:       return 8'hB0;
        4:       return 8'h99;
        5:       return 8'h92;
        6:       return 8'h82;
        7:       return 8'hF8;
        8:       return 8'h80;
        default: return 8'h90;
      endcase
    endfunction

    function logic [7:0] letter_glyph(int l);
      case (l)
        0:       return 8'h88;
        1:       return 8'h83;
        2:       return 8'hC6;
        3:       return 8'hA1;
        4:       return 8'h86;
        5:       return 8'h8E;
        6:       return 8'hC2;
        7:       return 8'h89;
        8:       return 8'hF9;
        9:       return 8'hF1;
        10:      return 8'h8A;
        11:      return 8'hC7;
        12:      return 8'hC8;
        13:      return 8'hAB;
        14:      return 8'hC0;
        15:      return 8'h8C;
        16:      return 8'h98;
        17:      return 8'hAF;
        18:      return 8'h92;
        19:      return 8'h87;
        20:      return 8'hC1;
        21:      return 8'hC1;
        22:      return 8'h85;
        23:      return 8'h89;
        24:      return 8'h91;
        default: return 8'hA4;
      endcase
    endfunction

    function logic [7:0] position_select(int i);
      return 8'hF0 | (8'h01 << i);
    endfunction

    function void show_number(command_t c);
      int  v;
      int  digs [POSITIONS];
      bit  significant;
      v = int'(c.number);
      significant = 0;
      if (v < 0 || v > MAX_SHOWN) begin
        for (int i = 0; i < POSITIONS; i++) glyphs[i] = SEG_ALL_ON;
        return;
      end
      for (int i = POSITIONS - 1; i >= 0; i--) begin
        digs[i] = v % 10;
        v = v / 10;
      end
      for (int i = 0; i < POSITIONS; i++) begin
        if (digs[i] != 0) significant = 1;
        if (significant || c.leading_zeros || i == POSITIONS - 1)
          glyphs[i] = digit_glyph(digs[i]);
        else
          glyphs[i] = SEG_BLANK;
      end
    endfunction

    function void note_command(command_t c);
      frame_t f;
      commands++;
      case (c.kind)
        KIND_DIGIT: begin
          if (c.position < POSITIONS && c.char_code <= 9)
            glyphs[c.position] = digit_glyph(int'(c.char_code));
        end
        KIND_LETTER: begin
          if (c.position < POSITIONS) begin
            if (c.char_code >= ASCII_UPPER_A && c.char_code <= ASCII_UPPER_Z)
              glyphs[c.position] = letter_glyph(int'(c.char_code - ASCII_UPPER_A));
            else if (c.char_code >= ASCII_LOWER_A && c.char_code <= ASCII_LOWER_Z)
              glyphs[c.position] = letter_glyph(int'(c.char_code - ASCII_LOWER_A));
          end
        end
        KIND_NUMBER: begin
          show_number(c);
        end
        KIND_CLEAR: begin
          for (int i = 0; i < POSITIONS; i++) begin
            glyphs[i]  = SEG_BLANK;
            f.pattern  = SEG_BLANK;
            f.sel_byte = position_select(i);
            f.last     = (i == POSITIONS - 1);
            pending.push_back(f);
          end
        end
        KIND_REFRESH: begin
          f.pattern  = glyphs[scan_pos];
          f.sel_byte = position_select(int'(scan_pos));
          f.last     = 1'b1;
          pending.push_back(f);
          scan_pos   = scan_pos + 2'd1;
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
    endtask

    task check_frame(frame_t got);
      frame_t want;
      frames_checked++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected frame pattern=%h select=%h last=%b",
                                  got.pattern, got.sel_byte, got.last));
        return;
      end
      want = pending.pop_front();
      if (got.pattern !== want.pattern)
        report_mismatch($sformatf("segment_pattern %h, expected %h", got.pattern,
                                  want.pattern));
      if (got.sel_byte !== want.sel_byte)
        report_mismatch($sformatf("digit_select %h, expected %h", got.sel_byte,
                                  want.sel_byte));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask

    function int pending_count();
      return pending.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ssd_in_if  in_chan ();
  ssd_out_if out_chan ();

  seven_segment_scan_driver_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  frame_scoreboard frame_sb = new();

  int burst_left;
  int refresh_sent;
  int clear_sent;

  int          stall_mode;
  int          mode_left;
  logic [15:0] stall_pattern;
  int          pattern_bit;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    command_t c;
    frame_t   f;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      c.kind          = in_chan.kind;
      c.position      = in_chan.position;
      c.char_code     = in_chan.char_code;
      c.number        = in_chan.number;
      c.leading_zeros = in_chan.leading_zeros;
      frame_sb.note_command(c);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      f.pattern  = out_chan.segment_pattern;
      f.sel_byte = out_chan.digit_select;
      f.last     = out_chan.last;
      frame_sb.check_frame(f);
    end
  end

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode    = $urandom_range(0, 2);
      mode_left     = $urandom_range(10, 60);
      stall_pattern = 16'($urandom()) | 16'h0001;
      pattern_bit   = 0;
    end
    mode_left--;
    case (stall_mode)
      0:       out_chan.ready = 1'b1;
      1:       out_chan.ready = 1'($urandom_range(0, 1));
      default: begin
        out_chan.ready = stall_pattern[pattern_bit];
        pattern_bit    = (pattern_bit + 1) % 16;
      end
    endcase
  end

  task send_command(command_t c);
    if (burst_left == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_chan.kind          = c.kind;
    in_chan.position      = c.position;
    in_chan.char_code     = c.char_code;
    in_chan.number        = c.number;
    in_chan.leading_zeros = c.leading_zeros;
    in_chan.valid         = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    if (c.kind == KIND_REFRESH) refresh_sent++;
    if (c.kind == KIND_CLEAR) clear_sent++;
  endtask

  task send_fields(logic [2:0] kind, logic [2:0] pos, logic [7:0] code,
                   logic signed [15:0] num, logic keep);
    command_t c;
    c.kind          = kind;
    c.position      = pos;
    c.char_code     = code;
    c.number        = num;
    c.leading_zeros = keep;
    send_command(c);
  endtask

  task scan_all();
    repeat (POSITIONS) send_fields(KIND_REFRESH, 3'd0, 8'd0, 16'sd0, 1'b0);
  endtask

  function command_t random_command();
    command_t c;
    int       pick;
    c.kind          = 3'($urandom_range(0, 7));
    c.position      = 3'($urandom_range(0, 7));
    c.char_code     = 8'($urandom_range(0, 255));
    c.number        = 16'($urandom_range(0, 65535));
    c.leading_zeros = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      c.kind = KIND_REFRESH;
    end else if (pick < 50) begin
      c.kind = KIND_DIGIT;
      if ($urandom_range(0, 9) != 0) c.position = 3'($urandom_range(0, POSITIONS - 1));
      if ($urandom_range(0, 9) != 0) c.char_code = 8'($urandom_range(0, 9));
    end else if (pick < 65) begin
      c.kind = KIND_LETTER;
      if ($urandom_range(0, 9) != 0) c.position = 3'($urandom_range(0, POSITIONS - 1));
      case ($urandom_range(0, 4))
        0, 1:    c.char_code = 8'($urandom_range(ASCII_UPPER_A, ASCII_UPPER_Z));
        2, 3:    c.char_code = 8'($urandom_range(ASCII_LOWER_A, ASCII_LOWER_Z));
        default: c.char_code = 8'($urandom_range(0, 255));
      endcase
    end else if (pick < 85) begin
      c.kind = KIND_NUMBER;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: c.number = 16'($urandom_range(0, MAX_SHOWN));
        10, 11, 12, 13:               c.number = 16'($urandom_range(0, 99));
        14, 15, 16:                   c.number = 16'($urandom_range(0, 65535));
        17:                           c.number = 16'(MAX_SHOWN);
        18:                           c.number = 16'(MAX_SHOWN + 1);
        default:                      c.number = -16'sd1;
      endcase
    end else if (pick < 92) begin
      c.kind = KIND_CLEAR;
    end else if (pick < 95) begin
      c.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end
    return c;
  endfunction

  initial begin
    command_t c;
    int       counted;
    int       drain_wait;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.kind          = '0;
    in_chan.position      = '0;
    in_chan.char_code     = '0;
    in_chan.number        = '0;
    in_chan.leading_zeros = 1'b0;
    out_chan.ready        = 1'b0;
    burst_left            = 0;
    refresh_sent          = 0;
    clear_sent            = 0;
    mode_left             = 0;
    counted               = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    scan_all();
    send_fields(KIND_DIGIT,  3'd0, 8'd0,   16'sd0, 1'b0);
    send_fields(KIND_DIGIT,  3'd3, 8'd9,   16'sd0, 1'b1);
    send_fields(KIND_DIGIT,  3'd1, 8'd10,  16'sd0, 1'b0);
    send_fields(KIND_DIGIT,  3'd2, 8'hFF,  16'sd0, 1'b0);
    send_fields(KIND_DIGIT,  3'd4, 8'd5,   16'sd0, 1'b0);
    send_fields(KIND_LETTER, 3'd7, ASCII_UPPER_A, 16'sd0, 1'b0);
    send_fields(KIND_LETTER, 3'd1, ASCII_UPPER_Z, 16'sd0, 1'b0);
    send_fields(KIND_LETTER, 3'd2, ASCII_LOWER_A, 16'sd0, 1'b0);
    send_fields(KIND_LETTER, 3'd2, ASCII_UPPER_Z + 8'd1, 16'sd0, 1'b0);
    send_fields(KIND_LETTER, 3'd1, ASCII_LOWER_A - 8'd1, 16'sd0, 1'b0);
    send_fields(KIND_LETTER, 3'd0, 8'h80,  16'sd0, 1'b0);
    scan_all();
    send_fields(KIND_NUMBER, 3'd0, 8'd0,   16'sd0,    1'b0);
    scan_all();
    send_fields(KIND_NUMBER, 3'd0, 8'd0,   16'sd105,  1'b1);
    scan_all();
    send_fields(KIND_NUMBER, 3'd0, 8'd0,   16'sd10000, 1'b0);
    send_fields(KIND_REFRESH, 3'd0, 8'd0,  16'sd0,    1'b0);
    send_fields(KIND_NUMBER, 3'd0, 8'd0,   16'sd9999, 1'b0);
    send_fields(KIND_REFRESH, 3'd0, 8'd0,  16'sd0,    1'b0);
    send_fields(KIND_NUMBER, 3'd0, 8'd0,   -16'sd32768, 1'b1);
    send_fields(KIND_REFRESH, 3'd0, 8'd0,  16'sd0,    1'b0);
    send_fields(KIND_LETTER, 3'd3, ASCII_LOWER_Z, 16'sd0, 1'b0);
    send_fields(KIND_CLEAR,  3'd7, 8'hFF,  16'sd32767, 1'b1);
    send_fields(KIND_UNUSED_LO, 3'd0, 8'd0, 16'sd0,   1'b0);
    send_fields(KIND_UNUSED_HI, 3'd7, 8'hFF, -16'sd1, 1'b1);
    scan_all();

    while (counted < TARGET_ITEMS) begin
      c = random_command();
      send_command(c);
      if (c.kind <= KIND_REFRESH) counted++;
    end
    in_chan.valid = 1'b0;

    while (frame_sb.pending_count() != 0) @(posedge clk);
    drain_wait = 0;
    while (drain_wait < DRAIN_CYCLES) begin
      @(posedge clk);
      drain_wait++;
    end

    $display("Sent %0d commands, %0d refresh ticks and %0d clears; checked %0d frames.",
             frame_sb.commands, refresh_sent, clear_sent, frame_sb.frames_checked);
    if (frame_sb.errors == 0 && frame_sb.pending_count() == 0) begin
      $display("seven_segment_scan_driver_core verification clean");
    end else begin
      if (frame_sb.pending_count() != 0)
        $display("%0d expected frames never arrived.", frame_sb.pending_count());
      $display("seven_segment_scan_driver_core verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d frames outstanding.", frame_sb.pending_count());
    $display("seven_segment_scan_driver_core verification failed");
    $finish;
  end

endmodule
